// ----- design/plti_pkg.sv -----
package plti_pkg;

  // Field widths
  localparam int unsigned ACT_W = 2;
  localparam int unsigned WL_W  = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;

  // Divider: one integer quotient bit plus sixteen fraction bits
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned QUO_W     = FRAC_W + 1;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned DCNT_W    = 5;

  // Arithmetic widths
  localparam int unsigned DV_W   = VAL_W + 1;
  localparam int unsigned PROD_W = DV_W + QUO_W + 1;
  localparam int unsigned SUM_W  = PROD_W - FRAC_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FEW   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Table read address source
  typedef enum logic [2:0] {
    RD_FIRST = 3'd0,
    RD_LAST  = 3'd1,
    RD_MID   = 3'd2,
    RD_LO    = 3'd3,
    RD_HI    = 3'd4
  } rd_sel_e;

  // Working result source
  typedef enum logic [1:0] {
    RES_HOLD = 2'd0,
    RES_ZERO = 2'd1,
    RES_V0   = 2'd2,
    RES_SUM  = 2'd3
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     latch_in;
    logic     clear_cnt;
    logic     append;
    rd_sel_e  rd_sel;
    logic     search_init;
    logic     search_mid;
    logic     search_upd;
    logic     cap_lo;
    logic     cap_hi;
    logic     div_step;
    logic     mul_en;
    res_sel_e res_sel;
    status_e  res_status;
    logic     load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             cnt_lt2;
    logic             full;
    logic             below_first;
    logic             above_last;
    logic             span_gt1;
    logic             flat;
    logic             div_last;
  } sts_t;

endpackage

// ----- design/plti_req_if.sv -----
interface plti_req_if;
  logic                         valid;
  logic                         ready;
  logic [plti_pkg::ACT_W-1:0]   action;
  logic [plti_pkg::WL_W-1:0]    wavelength;
  logic signed [plti_pkg::VAL_W-1:0] point_value;

  modport source (output valid, action, wavelength, point_value, input ready);
  modport sink (input valid, action, wavelength, point_value, output ready);
endinterface

// ----- design/plti_rsp_if.sv -----
interface plti_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [plti_pkg::VAL_W-1:0] result_value;
  logic [plti_pkg::ST_W-1:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// ----- design/piecewise_linear_table_interp.sv -----
// Piecewise-linear lookup table with one request in flight at a time.
// Clear, append, unused action and short-table queries respond straight from the execute state.
// Out-of-range queries respond after the first-point check (below) or the last-point check (above).
// Full query: binary search for the bracket, then divide, multiply and sum; equal brackets skip
// the divider; next request is taken with the response.
// Reset (async, active low) empties the table; stored entries are not cleared.
module piecewise_linear_table_interp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plti_req_if.sink   req_i,
  plti_rsp_if.source rsp_o
);
  import plti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  plti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, search, divider and multiplier
  plti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (req_i.action),
    .wavelength_i   (req_i.wavelength),
    .point_value_i  (req_i.point_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_value_o (rsp_o.result_value),
    .status_o       (rsp_o.status)
  );

endmodule

// ----- design/plti_ctrl.sv -----
module plti_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  plti_pkg::sts_t sts_i,
  output plti_pkg::cmd_t cmd_o
);
  import plti_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_EXEC   = 13'b0000000000010,
    S_FIRST  = 13'b0000000000100,
    S_LAST   = 13'b0000000001000,
    S_SEARCH = 13'b0000000010000,
    S_PROBE  = 13'b0000000100000,
    S_GETLO  = 13'b0000001000000,
    S_GETHI  = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_MUL    = 13'b0001000000000,
    S_SUM    = 13'b0010000000000,
    S_OUT    = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel     = RD_LO;
    cmd_o.res_sel    = RES_HOLD;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_sel    = RES_ZERO;
        cmd_o.res_status = ST_OK;
        state_d          = S_OUT;
        unique case (sts_i.action)
          ACT_CLEAR: cmd_o.clear_cnt = 1'b1;
          ACT_APPEND: begin
            if (sts_i.full) cmd_o.res_status = ST_FULL;
            else cmd_o.append = 1'b1;
          end
          ACT_QUERY: begin
            if (sts_i.cnt_lt2) begin
              cmd_o.res_status = ST_FEW;
            end else begin
              cmd_o.res_sel = RES_HOLD;
              cmd_o.rd_sel  = RD_FIRST;
              state_d       = S_FIRST;
            end
          end
          default: ;
        endcase
      end
      S_FIRST: begin
        if (sts_i.below_first) begin
          cmd_o.res_sel    = RES_ZERO;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_OUT;
        end else begin
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_LAST;
        end
      end
      S_LAST: begin
        if (sts_i.above_last) begin
          cmd_o.res_sel    = RES_ZERO;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_OUT;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.span_gt1) begin
          cmd_o.rd_sel     = RD_MID;
          cmd_o.search_mid = 1'b1;
          state_d          = S_PROBE;
        end else begin
          cmd_o.rd_sel = RD_LO;
          state_d      = S_GETLO;
        end
      end
      S_PROBE: begin
        cmd_o.search_upd = 1'b1;
        state_d          = S_SEARCH;
      end
      S_GETLO: begin
        cmd_o.cap_lo = 1'b1;
        cmd_o.rd_sel = RD_HI;
        state_d      = S_GETHI;
      end
      S_GETHI: begin
        cmd_o.cap_hi = 1'b1;
        if (sts_i.flat) begin
          cmd_o.res_sel = RES_V0;
          state_d       = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.res_sel = RES_SUM;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/plti_dp.sv -----
module plti_dp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [plti_pkg::ACT_W-1:0]        action_i,
  input  logic [plti_pkg::WL_W-1:0]         wavelength_i,
  input  logic signed [plti_pkg::VAL_W-1:0] point_value_i,
  input  plti_pkg::cmd_t                    cmd_i,
  output plti_pkg::sts_t                    sts_o,
  output logic signed [plti_pkg::VAL_W-1:0] result_value_o,
  output logic [plti_pkg::ST_W-1:0]         status_o
);
  import plti_pkg::*;

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

  // Table storage
  logic [WL_W-1:0]         wmem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] vmem [TABLE_DEPTH];

  logic [ACT_W-1:0]        act_q;
  logic [WL_W-1:0]         q_q;
  logic signed [VAL_W-1:0] pv_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [AW-1:0]           lo_q, hi_q, mid_q, mid, rd_addr, last_idx;
  logic [AW:0]             mid_sum;
  logic [WL_W-1:0]         rd_w_q, w0_q, den_q;
  logic signed [VAL_W-1:0] rd_v_q, v0_q;
  logic signed [DV_W-1:0]  dv_q;
  logic [QUO_W-1:0]        rem_q, quo_q, rem_sub;
  logic [DCNT_W-1:0]       dcnt_q;
  logic                    rem_ge;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] res_q, out_val_q;
  status_e                 st_q;
  logic [ST_W-1:0]         out_st_q;

  assign last_idx = AW'(cnt_q - CNT_W'(1));
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[AW:1];

  // Read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = last_idx;
      RD_MID:   rd_addr = mid;
      RD_LO:    rd_addr = lo_q;
      RD_HI:    rd_addr = hi_q;
      default:  rd_addr = lo_q;
    endcase
  end

  // Table write port and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      wmem[cnt_q[AW-1:0]] <= q_q;
      vmem[cnt_q[AW-1:0]] <= pv_q;
    end
    rd_w_q <= wmem[rd_addr];
    rd_v_q <= vmem[rd_addr];
  end

  // Point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear_cnt) begin
      cnt_q <= '0;
    end else if (cmd_i.append) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Divider step: remainder stays below twice the span
  assign rem_ge  = (rem_q >= {1'b0, den_q});
  assign rem_sub = rem_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  // Interpolation sum, product floored by arithmetic shift
  assign sum = SUM_W'(v0_q) + prod_q[PROD_W-1:FRAC_W];

  // Request latch, search, divide, multiply and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q <= action_i;
      q_q   <= wavelength_i;
      pv_q  <= point_value_i;
    end
    if (cmd_i.search_init) begin
      lo_q <= '0;
      hi_q <= last_idx;
    end
    if (cmd_i.search_mid) mid_q <= mid;
    if (cmd_i.search_upd) begin
      if (rd_w_q <= q_q) lo_q <= mid_q;
      else hi_q <= mid_q;
    end
    if (cmd_i.cap_lo) begin
      w0_q <= rd_w_q;
      v0_q <= rd_v_q;
    end
    if (cmd_i.cap_hi) begin
      dv_q   <= DV_W'(rd_v_q) - DV_W'(v0_q);
      den_q  <= rd_w_q - w0_q;
      rem_q  <= {1'b0, q_q - w0_q};
      quo_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[QUO_W-2:0], 1'b0};
      quo_q  <= {quo_q[QUO_W-2:0], rem_ge};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (cmd_i.mul_en) prod_q <= dv_q * $signed({1'b0, quo_q});
    unique case (cmd_i.res_sel)
      RES_ZERO: begin
        res_q <= '0;
        st_q  <= cmd_i.res_status;
      end
      RES_V0: begin
        res_q <= v0_q;
        st_q  <= ST_OK;
      end
      RES_SUM: begin
        if (sum > SAT_MAX) res_q <= VAL_W'(SAT_MAX);
        else if (sum < SAT_MIN) res_q <= VAL_W'(SAT_MIN);
        else res_q <= VAL_W'(sum);
        st_q <= ST_OK;
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_val_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  // Status to controller
  always_comb begin
    sts_o             = '0;
    sts_o.action      = act_q;
    sts_o.cnt_lt2     = (cnt_q < CNT_W'(2));
    sts_o.full        = (cnt_q == CNT_W'(TABLE_DEPTH));
    sts_o.below_first = (q_q < rd_w_q);
    sts_o.above_last  = (q_q > rd_w_q);
    sts_o.span_gt1    = ((hi_q - lo_q) > AW'(1));
    sts_o.flat        = (rd_w_q <= w0_q);
    sts_o.div_last    = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
  end

  assign result_value_o = out_val_q;
  assign status_o       = out_st_q;

endmodule

// ----- design/plti_chk.sv -----
module plti_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic signed [plti_pkg::VAL_W-1:0] result_value_i,
  input logic [plti_pkg::ST_W-1:0]         status_i
);
  import plti_pkg::*;

  // A stalled response stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(result_value_i) && $stable(status_i))
    else $error("response payload changed while stalled");

  // Only one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

  // Every non-ok status carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_OK) |-> result_value_i == '0)
    else $error("error response with nonzero value");

endmodule

bind piecewise_linear_table_interp plti_chk u_plti_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .result_value_i (rsp_o.result_value),
  .status_i       (rsp_o.status)
);
